/* design/snoi_pkg.sv */
// Shared types and constants for the octave simplex noise block.
// Used by snoi_front, snoi_back and the top level; no dependencies.
package snoi_pkg;

  localparam int PERM_ENTRIES = 256;
  localparam int TOTAL_W      = 52;   // weighted octave sum, signed Q32
  localparam int WSUM_W       = 21;   // amplitude sum, Q16
  localparam int OFS_W        = 20;   // corner offsets, signed Q16

  localparam logic signed [19:0] F2_Q20 = 20'sd383805;
  localparam logic signed [18:0] G2_Q20 = 19'sd221590;
  localparam logic signed [19:0] G2_Q16 = 20'sd13849;
  localparam logic signed [7:0]  NOISE_SCALE = 8'sd70;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic [7:0]         table_index;
    logic [7:0]         table_value;
  } item_t;

  // head of the front queue as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SCALE, ST_SKEW, ST_CELL, ST_UNSKEW, ST_OFFS, ST_CORN,
    ST_H0, ST_H1, ST_H2, ST_H3,
    ST_CQ, ST_CW, ST_CQ2, ST_CQ4, ST_CN,
    ST_VAL, ST_ACC, ST_DIV, ST_DIVL, ST_OUT
  } back_state_t;

  // gradient dot product; gradients are unit steps so no multiplier
  function automatic logic signed [21:0] grad_dot(input logic [2:0] g,
                                                  input logic signed [19:0] xv,
                                                  input logic signed [19:0] yv);
    logic signed [21:0] xe;
    logic signed [21:0] ye;
    xe = 22'(xv);
    ye = 22'(yv);
    unique case (g)
      3'd0: grad_dot = xe + ye;
      3'd1: grad_dot = ye - xe;
      3'd2: grad_dot = xe - ye;
      3'd3: grad_dot = -xe - ye;
      3'd4: grad_dot = xe;
      3'd5: grad_dot = -xe;
      3'd6: grad_dot = ye;
      3'd7: grad_dot = -ye;
      default: grad_dot = '0;
    endcase
  endfunction

endpackage

/* design/snoi_front.sv */
// Input side: takes stream transfers, decodes the operation and holds
// them in a two-entry queue for the back end. Depends on snoi_pkg.
module snoi_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [79:0]             s_tdata,  // x_coord, y_coord, table_index, table_value
  input  logic                    s_tuser,  // operation
  output snoi_pkg::q_head_t       head,
  input  logic                    pop
);
  import snoi_pkg::*;

  item_t      ent [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push;
  item_t      in_item;

  assign s_tready = (cnt != 2'd2);
  assign push     = s_tvalid && s_tready;

  always_comb begin
    in_item.op          = op_t'(s_tuser);
    in_item.x_coord     = s_tdata[31:0];
    in_item.y_coord     = s_tdata[63:32];
    in_item.table_index = s_tdata[71:64];
    in_item.table_value = s_tdata[79:72];
  end

  assign head.valid = (cnt != 2'd0);
  assign head.item  = ent[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop)  rp <= !rp;
      if (push && !pop)      cnt <= cnt + 2'd1;
      else if (pop && !push) cnt <= cnt - 2'd1;
    end
  end

endmodule

/* design/snoi_back.sv */
// Back end: permutation memory, per-octave simplex sequencer, weighted
// sum, serial divider and output register. Depends on snoi_pkg.
module snoi_back #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  snoi_pkg::q_head_t head,
  output logic              pop,
  input  logic [3:0]        octave_count,
  input  logic [15:0]       persistence,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata
);
  import snoi_pkg::*;

  localparam int KW = $clog2(MAX_OCTAVES + 1);

  back_state_t state, state_next;

  logic [7:0] perm_mem [PERM_ENTRIES];
  logic [7:0] perm_rd;
  logic [7:0] raddr;
  logic       mem_we;

  logic [KW-1:0] k, count_eff;
  logic [4:0]    oc5, cnt5;
  logic signed [31:0] xb, yb;
  logic signed [39:0] sx, sy;
  logic signed [60:0] skew_prod;
  logic signed [25:0] ci, cj;
  logic signed [41:0] t;
  logic signed [OFS_W-1:0] xc [3];
  logic signed [OFS_W-1:0] yc [3];
  logic [2:0]  gi [3];
  logic        i1;
  logic [7:0]  p0, p2j, pj1;
  logic [1:0]  c;
  logic [39:0] xsq, ysq;
  logic signed [21:0] dot;
  logic [31:0] qv, q2, q4;
  logic        live;
  logic signed [39:0] n;
  logic signed [31:0] v;
  logic signed [TOTAL_W-1:0] total;
  logic [WSUM_W-1:0] wsum;
  logic [16:0] amp;
  logic        neg;
  logic [TOTAL_W-1:0] dvd;
  logic [WSUM_W:0]    rem;
  logic [5:0]  dcnt;

  // combinational datapath
  logic signed [40:0] sum41;
  logic signed [60:0] skew_mul;
  logic signed [40:0] s41;
  logic signed [41:0] xs42, ys42;
  logic signed [26:0] ij;
  logic signed [45:0] t_mul;
  logic signed [43:0] x0f, y0f;
  logic        i1n;
  logic signed [39:0] sq_x, sq_y;
  logic signed [41:0] q_full;
  logic [63:0] q2m, q4m;
  logic signed [53:0] cm;
  logic signed [47:0] nm;
  logic signed [49:0] am;
  logic [32:0] pm;
  logic [WSUM_W:0]   dvs;
  logic [WSUM_W+1:0] trial;
  logic        ge;
  logic [TOTAL_W:0] mag;
  logic [15:0] res;
  logic        out_free;

  assign oc5  = {1'b0, octave_count};
  assign cnt5 = (oc5 == 5'd0) ? 5'd1 :
                (oc5 > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) : oc5;

  assign sum41    = {sx[39], sx} + {sy[39], sy};
  assign skew_mul = sum41 * F2_Q20;
  assign s41      = skew_prod[60:20];
  assign xs42     = {{2{sx[39]}}, sx} + {s41[40], s41};
  assign ys42     = {{2{sy[39]}}, sy} + {s41[40], s41};
  assign ij       = {ci[25], ci} + {cj[25], cj};
  assign t_mul    = ij * G2_Q20;
  assign x0f = {{4{sx[39]}}, sx} - {{2{ci[25]}}, ci, 16'd0} + {{2{t[41]}}, t};
  assign y0f = {{4{sy[39]}}, sy} - {{2{cj[25]}}, cj, 16'd0} + {{2{t[41]}}, t};
  assign i1n      = xc[0] > yc[0];
  assign sq_x     = xc[c] * xc[c];
  assign sq_y     = yc[c] * yc[c];
  assign q_full   = 42'sh0_8000_0000 - $signed({2'b00, xsq}) - $signed({2'b00, ysq});
  assign q2m      = qv * qv;
  assign q4m      = q2 * q2;
  assign cm       = $signed({1'b0, q4}) * dot;
  assign nm       = n * NOISE_SCALE;
  assign am       = v * $signed({1'b0, amp});
  assign pm       = amp * persistence;
  assign dvs      = {wsum, 1'b0};
  assign trial    = {rem, dvd[TOTAL_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign mag      = {1'b0, dvd} + (TOTAL_W+1)'(rem != '0);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    if (!neg) begin
      res = (dvd > TOTAL_W'(32767)) ? 16'h7FFF : dvd[15:0];
    end else begin
      res = (mag > (TOTAL_W+1)'(32768)) ? 16'h8000 : 16'd0 - mag[15:0];
    end
  end

  // permutation memory, registered read
  always_comb begin
    unique case (state)
      ST_OFFS: raddr = cj[7:0] + 8'd1;
      ST_CORN: raddr = cj[7:0] + {7'd0, !i1n};
      ST_H0:   raddr = ci[7:0] + p0;
      ST_H1:   raddr = ci[7:0] + {7'd0, i1} + pj1;
      ST_H2:   raddr = ci[7:0] + 8'd1 + p2j;
      default: raddr = cj[7:0];
    endcase
  end

  assign mem_we = (state == ST_IDLE) && head.valid && (head.item.op == OP_LOAD);
  assign pop    = (state == ST_IDLE) && head.valid;

  always_ff @(posedge clk) begin
    if (mem_we) perm_mem[head.item.table_index] <= head.item.table_value;
    perm_rd <= perm_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (head.valid && head.item.op == OP_EVAL) state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_SKEW;
      ST_SKEW:   state_next = ST_CELL;
      ST_CELL:   state_next = ST_UNSKEW;
      ST_UNSKEW: state_next = ST_OFFS;
      ST_OFFS:   state_next = ST_CORN;
      ST_CORN:   state_next = ST_H0;
      ST_H0:     state_next = ST_H1;
      ST_H1:     state_next = ST_H2;
      ST_H2:     state_next = ST_H3;
      ST_H3:     state_next = ST_CQ;
      ST_CQ:     state_next = ST_CW;
      ST_CW:     state_next = ST_CQ2;
      ST_CQ2:    state_next = ST_CQ4;
      ST_CQ4:    state_next = ST_CN;
      ST_CN:     state_next = (c == 2'd2) ? ST_VAL : ST_CQ;
      ST_VAL:    state_next = ST_ACC;
      ST_ACC:    state_next = ((k + KW'(1)) == count_eff) ? ST_DIV : ST_SCALE;
      ST_DIV:    state_next = ST_DIVL;
      ST_DIVL:   if (dcnt == 6'(TOTAL_W - 1)) state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        xb        <= head.item.x_coord;
        yb        <= head.item.y_coord;
        k         <= '0;
        count_eff <= cnt5[KW-1:0];
        total     <= '0;
        wsum      <= '0;
        amp       <= 17'h10000;
      end
      ST_SCALE: begin
        sx <= {{8{xb[31]}}, xb} << k;
        sy <= {{8{yb[31]}}, yb} << k;
      end
      ST_SKEW: skew_prod <= skew_mul;
      ST_CELL: begin
        ci <= xs42[41:16];
        cj <= ys42[41:16];
      end
      ST_UNSKEW: t <= t_mul[45:4];
      ST_OFFS: begin
        xc[0] <= x0f[OFS_W-1:0];
        yc[0] <= y0f[OFS_W-1:0];
        p0    <= perm_rd;
      end
      ST_CORN: begin
        i1    <= i1n;
        xc[1] <= xc[0] - (i1n ? 20'sd65536 : 20'sd0) + G2_Q16;
        yc[1] <= yc[0] - (i1n ? 20'sd0 : 20'sd65536) + G2_Q16;
        xc[2] <= xc[0] - 20'sd65536 + (G2_Q16 <<< 1);
        yc[2] <= yc[0] - 20'sd65536 + (G2_Q16 <<< 1);
        p2j   <= perm_rd;
      end
      ST_H0: pj1 <= perm_rd;
      ST_H1: gi[0] <= perm_rd[2:0];
      ST_H2: gi[1] <= perm_rd[2:0];
      ST_H3: begin
        gi[2] <= perm_rd[2:0];
        c     <= 2'd0;
        n     <= '0;
      end
      ST_CQ: begin
        xsq <= sq_x;
        ysq <= sq_y;
        dot <= grad_dot(gi[c], xc[c], yc[c]);
      end
      ST_CW: begin
        live <= !q_full[41];
        qv   <= q_full[31:0];
      end
      ST_CQ2: q2 <= q2m[63:32];
      ST_CQ4: q4 <= q4m[63:32];
      ST_CN: begin
        if (live) n <= n + 40'($signed(cm[53:16]));
        c <= c + 2'd1;
      end
      ST_VAL: v <= nm[47:16];
      ST_ACC: begin
        total <= total + TOTAL_W'(am);
        wsum  <= wsum + WSUM_W'(amp);
        amp   <= pm[32:16];
        k     <= k + KW'(1);
      end
      ST_DIV: begin
        neg  <= total[TOTAL_W-1];
        dvd  <= total[TOTAL_W-1] ? TOTAL_W'(-total) : TOTAL_W'(total);
        rem  <= '0;
        dcnt <= '0;
      end
      ST_DIVL: begin
        rem  <= ge ? (WSUM_W+1)'(trial - {1'b0, dvs}) : trial[WSUM_W:0];
        dvd  <= {dvd[TOTAL_W-2:0], ge};
        dcnt <= dcnt + 6'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) m_tdata <= res;
  end

endmodule

/* design/simplex_noise_2d_octaves.sv */
// Top level of the octave simplex noise block: configuration registers,
// front queue and back end. Depends on snoi_pkg, snoi_front, snoi_back.
//
// Usage:
//   Input stream (s_t*): one transfer per item. s_tuser selects the
//   operation: load writes table_value into permutation entry table_index,
//   evaluate takes Q16.16 coordinates and yields one Q1.15 result.
//   Output stream (m_t*): one transfer per evaluate, in order; loads give
//   nothing. Fill all 256 table entries before evaluating.
//   Config: cfg_we writes cfg_data into register cfg_index (0 = octave
//   count, 1 = persistence) at the clock edge; write only while idle.
// Sequencing:
//   A load is written to the table from the idle state. In an evaluate, each
//   octave runs the skew, six serial permutation reads and three corner
//   passes of five steps; the final normalization is a 52-step bit-serial
//   divider.
//   A two-entry queue takes transfers while the back end works.
// Reset: rst (synchronous) empties the queue and output register and sets
//   octave count 4, persistence 0.5. Table contents are not cleared.
// Stall: a result waits in the output register; the back end holds there
//   until it is taken, and the queue fills and drops s_tready.
module simplex_noise_2d_octaves #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // x_coord, y_coord, table_index, table_value
  input  logic        s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // noise_value
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import snoi_pkg::*;

  localparam logic CFG_OCTAVES     = 1'b0;
  localparam logic CFG_PERSISTENCE = 1'b1;

  logic [3:0]  octave_count;
  logic [15:0] persistence;
  q_head_t     head;
  logic        pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= 4'd4;
      persistence  <= 16'd32768;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OCTAVES:     octave_count <= cfg_data[3:0];
        CFG_PERSISTENCE: persistence  <= cfg_data;
        default: ;
      endcase
    end
  end

  snoi_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .head     (head),
    .pop      (pop)
  );

  snoi_back #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .octave_count (octave_count),
    .persistence  (persistence),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata)
  );

endmodule

/* design/snoi_check.sv */
// Port-level checks for simplex_noise_2d_octaves, bound to the top level.
// Sees only the top-level ports; no package dependency.
module snoi_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // queue and output register come up empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("outputs not empty after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // the queue only fills on an input transfer
  a_ready_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(s_tready) |-> $past(s_tvalid))
    else $error("s_tready dropped without a transfer");

endmodule

bind simplex_noise_2d_octaves snoi_check u_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* tb/simplex_noise_2d_octaves_tb.sv */
// Testbench for simplex_noise_2d_octaves: fills the permutation table, then runs
// directed and random evaluates under several octave/persistence settings.
// Depends on snoi_pkg and the block's RTL; self-checking against its own predictor.
module simplex_noise_2d_octaves_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import snoi_pkg::*;

  localparam int OCT_LIMIT  = 8;
  localparam int DRAIN_WAIT = 320;   // outlasts the longest evaluate
  localparam logic CFG_OCTAVES = 1'b0;
  localparam logic CFG_PERSIST = 1'b1;

  class noise_scoreboard;
    logic [7:0]  perm [PERM_ENTRIES];
    logic [3:0]  octaves;
    logic [15:0] persist;
    logic signed [15:0] pending_noise[$];
    int errors;

    function new();
      octaves = 4;
      persist = 16'd32768;
      errors = 0;
      foreach (perm[i]) perm[i] = '0;
    endfunction

    function longint corner_term(longint xc, longint yc, logic [2:0] g);
      longint q, q2, q4, dot;
      q = (longint'(1) <<< 31) - xc * xc - yc * yc;
      if (q < 0) return 0;
      q2 = longint'((64'(q) * 64'(q)) >> 32);
      q4 = longint'((64'(q2) * 64'(q2)) >> 32);
      case (g)
        3'd0: dot = xc + yc;
        3'd1: dot = yc - xc;
        3'd2: dot = xc - yc;
        3'd3: dot = -xc - yc;
        3'd4: dot = xc;
        3'd5: dot = -xc;
        3'd6: dot = yc;
        default: dot = -yc;
      endcase
      return (q4 * dot) >>> 16;
    endfunction

    function longint octave_value(longint x, longint y);
      longint s, i, j, t, x0, y0, x1, y1, x2, y2, i1, j1, n;
      logic [7:0] ii, jj, h0, h1, h2;
      s = ((x + y) * 383805) >>> 20;
      i = (x + s) >>> 16;
      j = (y + s) >>> 16;
      t = ((i + j) * 221590) >>> 4;
      x0 = x - i * 65536 + t;
      y0 = y - j * 65536 + t;
      i1 = (x0 > y0) ? 1 : 0;
      j1 = 1 - i1;
      x1 = x0 - i1 * 65536 + 13849;
      y1 = y0 - j1 * 65536 + 13849;
      x2 = x0 - 65536 + 2 * 13849;
      y2 = y0 - 65536 + 2 * 13849;
      ii = 8'(i);
      jj = 8'(j);
      h0 = perm[8'(ii + perm[jj])];
      h1 = perm[8'(ii + 8'(i1) + perm[8'(jj + 8'(j1))])];
      h2 = perm[8'(ii + 8'd1 + perm[8'(jj + 8'd1)])];
      n = corner_term(x0, y0, h0[2:0]) + corner_term(x1, y1, h1[2:0])
        + corner_term(x2, y2, h2[2:0]);
      return (n * 70) >>> 16;
    endfunction

    function void note_input(op_t op, logic signed [31:0] xin, logic signed [31:0] yin,
                             logic [7:0] idx, logic [7:0] val);
      longint total, wsum, amp, d, q, sx, sy;
      logic signed [39:0] w;
      int cnt;
      if (op == OP_LOAD) begin
        perm[idx] = val;
        return;
      end
      total = 0;
      wsum = 0;
      amp = 65536;
      cnt = octaves;
      if (cnt < 1) cnt = 1;
      if (cnt > OCT_LIMIT) cnt = OCT_LIMIT;
      for (int k = 0; k < cnt; k++) begin
        w = 40'(longint'(xin) <<< k);
        sx = w;
        w = 40'(longint'(yin) <<< k);
        sy = w;
        total += octave_value(sx, sy) * amp;
        wsum += amp;
        amp = longint'((64'(amp) * 64'(persist)) >> 16);
      end
      d = 2 * wsum;
      q = total / d;
      if ((total % d) != 0 && total < 0) q--;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      pending_noise.push_back(16'(q));
    endfunction

    function void check(logic signed [15:0] got);
      logic signed [15:0] exp_v;
      if (pending_noise.size() == 0) begin
        $error("noise_value: unexpected result %0d", got);
        errors++;
        return;
      end
      exp_v = pending_noise.pop_front();
      if (got !== exp_v) begin
        $error("noise_value: expected %0d, actual %0d", exp_v, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [79:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  noise_scoreboard sb = new();
  bit idle_on = 1;
  int stall_left = 0;

  simplex_noise_2d_octaves dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // result side: check transfers, random stall bursts
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check(m_tdata);
    if (rst || !idle_on) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 4);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_item(op_t op, logic [31:0] xin, logic [31:0] yin,
                           logic [7:0] idx, logic [7:0] val);
    int gap;
    gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {val, idx, yin, xin};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(op, xin, yin, idx, val);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_noise.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_OCTAVES) sb.octaves = val[3:0];
    else sb.persist = val;
    @(posedge clk);
  endtask

  task automatic send_eval(logic [31:0] xin, logic [31:0] yin);
    send_item(OP_EVAL, xin, yin, 8'($urandom), 8'($urandom));
  endtask

  task automatic random_phase(int n);
    logic [31:0] xv, yv;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(OP_LOAD, $urandom, $urandom, 8'($urandom), 8'($urandom));
      end else begin
        case ($urandom_range(0, 2))
          0: begin xv = $urandom; yv = $urandom; end
          1: begin
            xv = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            yv = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
          end
          default: begin
            xv = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
            yv = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
          end
        endcase
        send_eval(xv, yv);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    m_tready = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every table entry written before any evaluate
    for (int i = 0; i < PERM_ENTRIES; i++)
      send_item(OP_LOAD, $urandom, $urandom, 8'(i), 8'($urandom));

    // directed evaluates at reset settings
    send_eval(32'h0, 32'h0);
    send_eval(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_eval(32'h8000_0000, 32'h8000_0000);
    send_eval(32'h7FFF_FFFF, 32'h8000_0000);
    send_eval(32'hFFFF_FFFF, 32'h0000_0001);
    send_eval(32'h0000_8000, 32'hFFFF_8000);
    send_eval(32'h0001_4000, 32'h0000_2000);
    drain();

    // octave count zero acts as one; persistence zero
    write_cfg(CFG_OCTAVES, 16'd0);
    write_cfg(CFG_PERSIST, 16'd0);
    send_eval(32'h0000_3000, 32'h0000_1000);
    send_eval(32'hFFFE_C000, 32'h0002_2000);
    random_phase(120);
    drain();

    // above the octave limit: clamps to eight
    write_cfg(CFG_OCTAVES, 16'd15);
    write_cfg(CFG_PERSIST, 16'hFFFF);
    send_eval(32'h7FFF_FFFF, 32'h8000_0000);
    random_phase(150);
    drain();

    write_cfg(CFG_OCTAVES, 16'd1);
    write_cfg(CFG_PERSIST, 16'd32768);
    random_phase(150);
    drain();

    write_cfg(CFG_OCTAVES, 16'd8);
    write_cfg(CFG_PERSIST, 16'($urandom));
    random_phase(120);
    drain();

    write_cfg(CFG_OCTAVES, 16'($urandom_range(2, 7)));
    write_cfg(CFG_PERSIST, 16'($urandom));
    random_phase(80);
    idle_on = 0;
    random_phase(80);
    drain();

    if (sb.errors == 0 && sb.pending_noise.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(12ns * 1_500_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
